### rtl/core/fit_policy_block_allocator_macros.svh
// Assertion macros shared by the allocator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define FPBA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("fpba assertion failed");

// Next-cycle implication, disabled while in reset.
`define FPBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("fpba assertion failed");

`endif

### rtl/core/fpba_pkg.sv
// Shared types and constants of the fit-policy block allocator.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package fpba_pkg;

  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIT_MODE    = 1'b0,
    CFG_BLOCK_COUNT = 1'b1
  } cfg_reg_e;

  // fit_mode register codes; the unused code behaves as first fit
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic [CFG_DATA_W-1:0] BLOCK_COUNT_RST = 5'd16;

  typedef struct packed {
    logic load;    // write one table entry from the input word
    logic init;    // latch request, restart scan
    logic issue;   // read the entry at the scan index
    logic finish;  // write back and strobe the result
  } fpba_cmd_t;

  typedef struct packed {
    logic last_issue;  // scan index is at the last entry in use
    logic limit_zero;  // nothing to scan
  } fpba_sts_t;

endpackage

`default_nettype wire

### rtl/core/fpba_ctrl.sv
// Controller of the allocator: one-hot state machine issuing datapath commands.
// Depends on fpba_pkg and fit_policy_block_allocator_macros.svh.
`default_nettype none

module fpba_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  op_i,
  input  fpba_pkg::fpba_sts_t   sts_i,
  output fpba_pkg::fpba_cmd_t   cmd_o,
  output logic                  busy_o
);
  import fpba_pkg::*;

`include "fit_policy_block_allocator_macros.svh"

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (op_i == OP_ALLOC) begin
            cmd_o.init = 1'b1;
            state_d    = sts_i.limit_zero ? ST_DONE : ST_SCAN;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      // last read word is compared here
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  `FPBA_ASSERT_NEXT(a_alloc_goes_busy, clk_i, rst_ni, start_i && !busy_o && op_i == OP_ALLOC, busy_o)
  `FPBA_ASSERT_NEXT(a_finish_then_idle, clk_i, rst_ni, cmd_o.finish, !busy_o)
  `FPBA_ASSERT_IMPL(a_load_only_idle, clk_i, rst_ni, cmd_o.load || cmd_o.init, !busy_o)

endmodule

`default_nettype wire

### rtl/core/fpba_dp.sv
// Datapath of the allocator: free-size table, scan compare, request counter, result regs.
// Depends on fpba_pkg and fit_policy_block_allocator_macros.svh.
`default_nettype none

module fpba_dp #(
  parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fpba_pkg::fpba_cmd_t                 cmd_i,
  output fpba_pkg::fpba_sts_t                 sts_o,
  input  logic                                cfg_we_i,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fpba_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [3:0]                          block_index_i,
  input  logic [15:0]                         size_value_i,
  input  logic                                last_request_i,
  output logic                                done_o,
  output logic                                granted_o,
  output logic [3:0]                          chosen_block_o,
  output logic [7:0]                          request_number_o,
  output logic                                last_out_o
);
  import fpba_pkg::*;

`include "fit_policy_block_allocator_macros.svh"

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int LIM_W = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
  localparam int BIX_W = (IDX_W > 4) ? IDX_W + 1 : 5;

  // configuration
  logic [1:0]            fit_mode_q;
  logic [CFG_DATA_W-1:0] block_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q    <= FIT_FIRST;
      block_count_q <= BLOCK_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FIT_MODE:    fit_mode_q    <= cfg_data_i[1:0];
        CFG_BLOCK_COUNT: block_count_q <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // input word shaping
  logic [SIZE_BITS+15:0] size_ext;
  logic [SIZE_BITS-1:0]  size_in;
  logic [IDX_W+3:0]      bidx_ext;
  logic [IDX_W-1:0]      load_addr;
  logic                  load_in_range;

  assign size_ext      = {{SIZE_BITS{1'b0}}, size_value_i};
  assign size_in       = size_ext[SIZE_BITS-1:0];
  assign bidx_ext      = {{IDX_W{1'b0}}, block_index_i};
  assign load_addr     = bidx_ext[IDX_W-1:0];
  assign load_in_range = (BIX_W'(block_index_i) < BIX_W'(NUM_BLOCKS));

  // scan limit, saturated to the table depth
  logic [LIM_W-1:0] bc_ext;
  logic [LIM_W-1:0] limit;

  assign bc_ext = LIM_W'(block_count_q);
  assign limit  = (bc_ext > LIM_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS) : bc_ext;

  logic [IDX_W-1:0] scan_idx_q;

  assign sts_o.limit_zero = (limit == '0);
  assign sts_o.last_issue = ((LIM_W'(scan_idx_q) + LIM_W'(1)) == limit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
    end else if (cmd_i.init) begin
      scan_idx_q <= '0;
    end else if (cmd_i.issue) begin
      scan_idx_q <= scan_idx_q + IDX_W'(1);
    end
  end

  // request latch
  logic [SIZE_BITS-1:0] req_q;
  logic                 last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      req_q  <= size_in;
      last_q <= last_request_i;
    end
  end

  // free-size table, one read and one write port
  logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
  logic [SIZE_BITS-1:0] rd_q;
  logic [IDX_W-1:0]     rd_idx_q;
  logic [SIZE_BITS-1:0] best_q;
  logic [IDX_W-1:0]     pick_q;
  logic                 found_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && load_in_range) begin
      mem[load_addr] <= size_in;
    end else if (cmd_i.finish && found_q) begin
      mem[pick_q] <= best_q - req_q;
    end
    if (cmd_i.issue) begin
      rd_q     <= mem[scan_idx_q];
      rd_idx_q <= scan_idx_q;
    end
  end

  logic rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue;
    end
  end

  // candidate compare; strict compares keep ties on the lower index
  logic fits, take;

  always_comb begin
    fits = (rd_q >= req_q);
    take = 1'b0;
    if (rd_vld_q && fits) begin
      if (!found_q) begin
        take = 1'b1;
      end else if (fit_mode_q == FIT_BEST) begin
        take = (rd_q < best_q);
      end else if (fit_mode_q == FIT_WORST) begin
        take = (rd_q > best_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.init) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_q <= rd_q;
      pick_q <= rd_idx_q;
    end
  end

  // batch numbering
  logic [7:0] cnt_q;
  logic [7:0] cnt_inc;

  assign cnt_inc = cnt_q + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.finish) begin
      cnt_q <= last_q ? 8'd0 : cnt_inc;
    end
  end

  // result word
  logic [IDX_W+3:0] pick_ext;
  logic             done_q;
  logic             granted_q;
  logic [3:0]       chosen_q;
  logic [7:0]       num_q;
  logic             last_out_q;

  assign pick_ext = {4'd0, pick_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      granted_q  <= found_q;
      chosen_q   <= found_q ? pick_ext[3:0] : 4'd0;
      num_q      <= cnt_inc;
      last_out_q <= last_q;
    end
  end

  assign done_o           = done_q;
  assign granted_o        = granted_q;
  assign chosen_block_o   = chosen_q;
  assign request_number_o = num_q;
  assign last_out_o       = last_out_q;

  `FPBA_ASSERT_NEXT(a_finish_strobes, clk_i, rst_ni, cmd_i.finish, done_o)
  `FPBA_ASSERT_IMPL(a_single_strobe, clk_i, rst_ni, done_o, !$past(done_o))
  `FPBA_ASSERT_IMPL(a_no_grant_zero, clk_i, rst_ni, done_o && !granted_o, chosen_block_o == 4'd0)

endmodule

`default_nettype wire

### rtl/core/fit_policy_block_allocator.sv
// Allocate: busy from the accepting edge through SCAN, one table entry read per cycle for
// entries 0 to L-1 with L = min(block_count, NUM_BLOCKS), DRAIN for the last compare and
// DONE for the write-back; only DONE when L is 0. done_o strobes in the first cycle with
// busy low again. Load: no result; busy stays low and the next word is taken next cycle.
// Reset: state machine idle, request counter 0, fit_mode 0, block_count 16; table undefined.
// done_o cannot be held off by the receiver.
`default_nettype none

module fit_policy_block_allocator #(
  parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            operation_i,
  input  logic [3:0]                      block_index_i,
  input  logic [15:0]                     size_value_i,
  input  logic                            last_request_i,
  input  logic                            cfg_we_i,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            done_o,
  output logic                            granted_o,
  output logic [3:0]                      chosen_block_o,
  output logic [7:0]                      request_number_o,
  output logic                            last_out_o
);
  import fpba_pkg::*;

  fpba_cmd_t cmd;
  fpba_sts_t sts;

  fpba_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (operation_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  fpba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .block_index_i    (block_index_i),
    .size_value_i     (size_value_i),
    .last_request_i   (last_request_i),
    .done_o           (done_o),
    .granted_o        (granted_o),
    .chosen_block_o   (chosen_block_o),
    .request_number_o (request_number_o),
    .last_out_o       (last_out_o)
  );

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for fit_policy_block_allocator: directed table, then random words.
// Depends on fpba_pkg for register indexes, op codes and fit mode codes.

module testbench;
  import fpba_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 24;     // covers the longest allocate
  localparam int DRAIN_CYCLES  = 30;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int NUM_PHASES    = 12;
  localparam logic [1:0] FIT_UNUSED = 2'd3;

  typedef struct packed {
    logic       granted;
    logic [3:0] chosen_block;
    logic [7:0] request_number;
    logic       last_out;
  } grant_t;

  typedef enum logic [1:0] {ROW_WORD, ROW_TYPED, ROW_REG} row_kind_e;

  // register rows: idx[0] is the register, size[4:0] the data
  typedef struct packed {
    row_kind_e   kind;
    logic        op;
    logic [3:0]  idx;
    logic [15:0] size;
    logic        last;
    grant_t      want;
  } dir_row_t;

  localparam grant_t NO_WANT = '0;
  localparam int DIR_ROWS = 25;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  logic operation_i;
  logic [3:0] block_index_i;
  logic [15:0] size_value_i;
  logic last_request_i;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic done_o;
  logic granted_o;
  logic [3:0] chosen_block_o;
  logic [7:0] request_number_o;
  logic last_out_o;

  // predictor state
  logic [15:0] free_sizes_q [NUM_BLOCKS_DEF];
  logic [1:0] fit_mode_q;
  logic [4:0] block_count_q;
  logic [7:0] batch_pos_q;

  grant_t pending_grants [$];
  dir_row_t dir_table [DIR_ROWS];
  int err_count = 0;
  int cycle_count = 0;
  int unsigned phase_counts [NUM_PHASES] = '{16, 1, 31, 0, 2, 8, 17, 5, 16, 3, 12, 16};

  fit_policy_block_allocator i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .block_index_i    (block_index_i),
    .size_value_i     (size_value_i),
    .last_request_i   (last_request_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .granted_o        (granted_o),
    .chosen_block_o   (chosen_block_o),
    .request_number_o (request_number_o),
    .last_out_o       (last_out_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    err_count++;
  endtask

  // Updates the table copy; returns 1 when the word yields a result.
  function automatic bit predict_word(input logic op, input logic [3:0] idx,
                                      input logic [15:0] size, input logic last,
                                      output grant_t g);
    int unsigned span;
    int unsigned pick;
    bit hit;
    g = NO_WANT;
    if (op == OP_LOAD) begin
      free_sizes_q[idx] = size;
      return 1'b0;
    end
    span = (block_count_q > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : block_count_q;
    hit = 1'b0;
    pick = 0;
    for (int unsigned j = 0; j < span; j++) begin
      if (free_sizes_q[j] >= size) begin
        if (!hit) begin
          hit = 1'b1;
          pick = j;
          if (fit_mode_q != FIT_BEST && fit_mode_q != FIT_WORST) break;
        end else if (fit_mode_q == FIT_BEST && free_sizes_q[j] < free_sizes_q[pick]) begin
          pick = j;
        end else if (fit_mode_q == FIT_WORST && free_sizes_q[j] > free_sizes_q[pick]) begin
          pick = j;
        end
      end
    end
    if (hit) free_sizes_q[pick] = free_sizes_q[pick] - size;
    batch_pos_q = batch_pos_q + 8'd1;
    g.granted = hit;
    g.chosen_block = hit ? 4'(pick) : 4'd0;
    g.request_number = batch_pos_q;
    g.last_out = last;
    if (last) batch_pos_q = 8'd0;
    return 1'b1;
  endfunction

  // Drives one word and holds it until the block takes it.
  task automatic send_word(input logic op, input logic [3:0] idx, input logic [15:0] size,
                           input logic last, input bit typed = 1'b0,
                           input grant_t want = NO_WANT);
    grant_t g;
    @(negedge clk_i);
    start <= 1'b1;
    operation_i <= op;
    block_index_i <= idx;
    size_value_i <= size;
    last_request_i <= last;
    do @(posedge clk_i); while (busy);
    if (predict_word(op, idx, size, last, g)) pending_grants.push_back(typed ? want : g);
  endtask

  task automatic idle_burst();
    int unsigned n;
    n = $urandom_range(1, 15);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Wait for the block to go quiet before touching a register.
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FIT_MODE:    fit_mode_q = data[1:0];
      CFG_BLOCK_COUNT: block_count_q = data;
      default: ;
    endcase
  endtask

  task automatic random_word(input bit no_last);
    logic op;
    logic [15:0] size;
    logic last;
    op = ($urandom_range(0, 99) < (no_last ? 10 : 35)) ? OP_LOAD : OP_ALLOC;
    if (op == OP_LOAD) begin
      size = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
    end else begin
      case ($urandom_range(0, 7))
        0:       size = 16'd0;
        1:       size = 16'hFFFF;
        2:       size = 16'($urandom_range(0, 65535));
        default: size = 16'($urandom_range(0, 2047));
      endcase
    end
    last = no_last ? 1'b0 : ($urandom_range(0, 7) == 0);
    send_word(op, 4'($urandom_range(0, 15)), size, last);
  endtask

  always @(posedge clk_i) begin : check_grants
    grant_t want;
    if (rst_ni && done_o) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("result word with nothing pending");
      end else begin
        want = pending_grants.pop_front();
        if (granted_o !== want.granted)
          report_mismatch($sformatf("granted %b, want %b", granted_o, want.granted));
        if (chosen_block_o !== want.chosen_block)
          report_mismatch($sformatf("chosen_block %0d, want %0d",
                                    chosen_block_o, want.chosen_block));
        if (request_number_o !== want.request_number)
          report_mismatch($sformatf("request_number %0d, want %0d",
                                    request_number_o, want.request_number));
        if (last_out_o !== want.last_out)
          report_mismatch($sformatf("last_out %b, want %b", last_out_o, want.last_out));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    rst_ni = 1'b0;
    start = 1'b0;
    operation_i = OP_LOAD;
    block_index_i = '0;
    size_value_i = '0;
    last_request_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_FIT_MODE;
    cfg_data_i = '0;
    foreach (free_sizes_q[k]) free_sizes_q[k] = '0;
    fit_mode_q = FIT_FIRST;
    block_count_q = BLOCK_COUNT_RST;
    batch_pos_q = 8'd0;

    dir_table = '{
      // empty scan range: never granted
      '{ROW_REG,   OP_LOAD,  4'(CFG_BLOCK_COUNT), 16'd0,     1'b0, NO_WANT},
      '{ROW_TYPED, OP_ALLOC, 4'd0,  16'd0,     1'b0, '{1'b0, 4'd0, 8'd1, 1'b0}},
      '{ROW_REG,   OP_LOAD,  4'(CFG_BLOCK_COUNT), 16'd4,     1'b0, NO_WANT},
      '{ROW_WORD,  OP_LOAD,  4'd0,  16'd10,    1'b0, NO_WANT},
      '{ROW_WORD,  OP_LOAD,  4'd1,  16'd30,    1'b0, NO_WANT},
      '{ROW_WORD,  OP_LOAD,  4'd2,  16'd20,    1'b0, NO_WANT},
      '{ROW_WORD,  OP_LOAD,  4'd3,  16'hFFFF,  1'b0, NO_WANT},
      '{ROW_WORD,  OP_LOAD,  4'd15, 16'hFFFF,  1'b0, NO_WANT},
      // first fit skips a block that is too small
      '{ROW_WORD,  OP_ALLOC, 4'd0,  16'd15,    1'b0, NO_WANT},
      // zero request fits the first block and leaves it as is
      '{ROW_TYPED, OP_ALLOC, 4'd0,  16'd0,     1'b0, '{1'b1, 4'd0, 8'd3, 1'b0}},
      '{ROW_TYPED, OP_ALLOC, 4'd15, 16'hFFFF,  1'b1, '{1'b1, 4'd3, 8'd4, 1'b1}},
      // numbering restarts after the batch end
      '{ROW_TYPED, OP_ALLOC, 4'd0,  16'hFFFF,  1'b0, '{1'b0, 4'd0, 8'd1, 1'b0}},
      '{ROW_REG,   OP_LOAD,  4'(CFG_FIT_MODE), 16'(FIT_BEST), 1'b0, NO_WANT},
      '{ROW_WORD,  OP_ALLOC, 4'd0,  16'd12,    1'b0, NO_WANT},
      '{ROW_WORD,  OP_ALLOC, 4'd0,  16'd5,     1'b0, NO_WANT},
      '{ROW_WORD,  OP_LOAD,  4'd0,  16'd20,    1'b0, NO_WANT},
      '{ROW_WORD,  OP_ALLOC, 4'd0,  16'd20,    1'b0, NO_WANT},
      // worst fit, upper data bits set
      '{ROW_REG,   OP_LOAD,  4'(CFG_FIT_MODE), 16'({3'b111, FIT_WORST}), 1'b0, NO_WANT},
      '{ROW_WORD,  OP_LOAD,  4'd1,  16'd100,   1'b0, NO_WANT},
      '{ROW_WORD,  OP_LOAD,  4'd3,  16'd100,   1'b0, NO_WANT},
      '{ROW_WORD,  OP_ALLOC, 4'd0,  16'd1,     1'b0, NO_WANT},
      '{ROW_WORD,  OP_ALLOC, 4'd0,  16'd99,    1'b1, NO_WANT},
      // unused mode code acts as first fit
      '{ROW_REG,   OP_LOAD,  4'(CFG_FIT_MODE), 16'(FIT_UNUSED), 1'b0, NO_WANT},
      '{ROW_WORD,  OP_ALLOC, 4'd0,  16'd1,     1'b0, NO_WANT},
      '{ROW_REG,   OP_LOAD,  4'(CFG_FIT_MODE), 16'(FIT_FIRST), 1'b0, NO_WANT}
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_table[r]) begin
      if (dir_table[r].kind == ROW_REG) begin
        settle();
        write_reg(cfg_reg_e'(dir_table[r].idx[0]), dir_table[r].size[CFG_DATA_W-1:0]);
      end else begin
        send_word(dir_table[r].op, dir_table[r].idx, dir_table[r].size, dir_table[r].last,
                  dir_table[r].kind == ROW_TYPED, dir_table[r].want);
      end
    end

    // every entry written before any wider scan
    for (int k = 0; k < NUM_BLOCKS_DEF; k++)
      send_word(OP_LOAD, 4'(k), 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_reg(CFG_FIT_MODE, {3'($urandom_range(0, 7)), 2'(p % 4)});
      write_reg(CFG_BLOCK_COUNT, 5'(phase_counts[p]));
      // phase 5 runs one long batch so the request number wraps
      for (int i = 0; i < ((p == 5) ? 400 : 70); i++) begin
        if (p < 10 && p % 3 != 2 && $urandom_range(0, 3) == 0) idle_burst();
        random_word(p == 5);
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/fpba_pkg.sv
rtl/core/fpba_ctrl.sv
rtl/core/fpba_dp.sv
rtl/core/fit_policy_block_allocator.sv
tb/testbench.sv
